[src/lase_pkg.sv]
// Shared types, codes and fixed-point helpers of the LSTM amp sample engine.
package lase_pkg;

  localparam int ACCW = 40;

  localparam logic [1:0] CMD_PROC  = 2'd0;
  localparam logic [1:0] CMD_LOAD  = 2'd1;
  localparam logic [1:0] CMD_CLRV  = 2'd2;
  localparam logic [1:0] CMD_CLRA  = 2'd3;

  localparam logic [2:0] TAB_IN  = 3'd0;
  localparam logic [2:0] TAB_REC = 3'd1;
  localparam logic [2:0] TAB_GB  = 3'd2;
  localparam logic [2:0] TAB_DW  = 3'd3;
  localparam logic [2:0] TAB_DB  = 3'd4;

  localparam logic [1:0] CFG_HIDDEN = 2'd0;
  localparam logic [1:0] CFG_LAYERS = 2'd1;
  localparam logic [1:0] CFG_SKIP   = 2'd2;
  localparam logic [1:0] CFG_MODEL  = 2'd3;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_LOAD,
    S_G_BIAS, S_G_IN, S_G_REC, S_G_WAIT,
    S_EW0, S_EW1, S_EW2, S_EW3, S_EW4, S_EW5, S_EW6, S_EW7, S_EW8,
    S_D_BIAS, S_D_W, S_D_SKIP, S_D_WAIT, S_PUT
  } state_t;

  // operand pair fed to the shared multiplier
  typedef enum logic [3:0] {
    K_BIAS, K_X, K_IN, K_REC, K_DB, K_DW, K_SKIP, K_FC, K_IG, K_OT
  } kind_t;

  // floor(v / 4096 + 1/2), saturated to 16 bits
  function automatic logic signed [15:0] rnd_sat(input logic signed [ACCW-1:0] v);
    logic signed [ACCW:0]    t;
    logic signed [ACCW-12:0] q;
    t = $signed({v[ACCW-1], v}) + $signed((ACCW+1)'(2048));
    q = $signed(t[ACCW:12]);
    if (q > 32767)       return 16'sh7fff;
    else if (q < -32768) return 16'sh8000;
    else                 return 16'(q);
  endfunction

  // piecewise-linear sigmoid, result 0..4096
  function automatic logic [12:0] sig_q(input logic signed [16:0] x);
    logic [16:0] a;
    logic [12:0] y;
    a = x[16] ? 17'(-x) : 17'(x);
    if (a >= 17'd20480)     y = 13'd4096;
    else if (a >= 17'd9728) y = 13'(a >> 5) + 13'd3456;
    else if (a >= 17'd4096) y = 13'(a >> 3) + 13'd2560;
    else                    y = 13'(a >> 2) + 13'd2048;
    return x[16] ? (13'd4096 - y) : y;
  endfunction

  // tanh(x) = 2 * sigmoid(2x) - 1, result -4096..4096
  function automatic logic signed [13:0] tanh_q(input logic signed [15:0] x);
    logic [12:0]        s;
    logic signed [15:0] t;
    s = sig_q($signed({x, 1'b0}));
    t = $signed({2'b00, s, 1'b0}) - 16'sd4096;
    return t[13:0];
  endfunction

endpackage

[src/lstm_amp_sample_engine_core.sv]
// LSTM amp sample engine: sequencer, stores and one shared multiply-accumulate unit.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------------
//  in_     | input     | in_valid / in_ready  | cmd, voice, sample, weight address/value
//  out_    | output    | out_valid / out_ready| out_sample
//  cfg_    | input     | cfg_we (no wait)     | cfg_idx, cfg_wdata
//
// One word at a time: in_ready is high only in idle. A processed sample streams
// every product through one 17x17 multiplier, one term per cycle while a run of
// terms issues: per layer 4H rows of (1 + Lin + H) terms, each row drained
// before the next starts, then the element-wise steps S_EW0 to S_EW8 per hidden
// unit, then H + 1 dense terms, H + 2 with skip on. The multiplier and the single
// memory read port per store set this pace.
// Reset (rst_n low, synchronous) starts a clearing pass over the hidden and cell
// state, VOICES*MAX_LAYERS*MAX_HIDDEN entries; in_ready stays low meanwhile.
// A result waits in the output register; a stalled out_ready holds the next
// result in the engine until the register frees.
module lstm_amp_sample_engine_core
  import lase_pkg::*;
#(
  parameter int VOICES     = 8,
  parameter int MAX_HIDDEN = 32,
  parameter int MAX_LAYERS = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_cmd,
  input  logic [3:0]         in_voice,
  input  logic signed [15:0] in_sample,
  input  logic [2:0]         in_weight_table,
  input  logic [0:0]         in_weight_layer,
  input  logic [6:0]         in_weight_row,
  input  logic [4:0]         in_weight_col,
  input  logic signed [15:0] in_weight_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_sample,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_idx,
  input  logic [5:0]         cfg_wdata
);

  localparam int VW     = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int LW     = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
  localparam int LSW    = $clog2(MAX_LAYERS + 1);
  localparam int HIW    = (MAX_HIDDEN > 1) ? $clog2(MAX_HIDDEN) : 1;
  localparam int HSW    = $clog2(MAX_HIDDEN + 1);
  localparam int ROWS   = 4 * MAX_HIDDEN;
  localparam int RW     = $clog2(ROWS);
  localparam int VS     = MAX_LAYERS * MAX_HIDDEN;
  localparam int HDEPTH = VOICES * VS;
  localparam int HAW    = (HDEPTH > 1) ? $clog2(HDEPTH) : 1;
  localparam int GDEPTH = MAX_LAYERS * ROWS;
  localparam int GAW    = $clog2(GDEPTH);
  localparam int WDEPTH = GDEPTH * MAX_HIDDEN;
  localparam int WAW    = $clog2(WDEPTH);
  localparam int HRST   = (MAX_HIDDEN < 20) ? MAX_HIDDEN : 20;

  // configuration, held in clamped form
  logic [HSW-1:0] hs_r;
  logic [LSW-1:0] nl_r;
  logic           skip_r, model_r;

  state_t state_r, state_nxt;

  // latched input word
  logic [1:0]         cmd_r;
  logic [VW-1:0]      v_r;
  logic signed [15:0] x_r;
  logic [2:0]         ld_tab_r;
  logic [0:0]         ld_lay_r;
  logic [6:0]         ld_row_r;
  logic [4:0]         ld_col_r;
  logic signed [15:0] ld_val_r;

  // loop counters
  logic [LW-1:0]  l_r, l_nxt;
  logic [RW-1:0]  k_r, k_nxt;
  logic [HIW-1:0] j_r, j_nxt;
  logic [RW-1:0]  gr_r, gr_nxt;
  logic [HAW-1:0] clr_r, clr_nxt, clr_end_r, clr_end_nxt;

  // term issue into the multiply-accumulate pipe
  logic  iss_vld, iss_first, iss_last;
  kind_t iss_kind;
  logic  s1_vld_r, s1_first_r, s1_last_r;
  kind_t s1_kind_r;
  logic  p_vld_r, p_first_r, p_last_r;
  logic signed [33:0]     p_r;
  logic signed [ACCW-1:0] acc_r;
  logic                   done_r;
  logic signed [16:0]     mul_a, mul_b;
  logic signed [15:0]     rnd;

  // per-unit element-wise registers
  logic [12:0]        ig_r, fg_r, og_r;
  logic signed [13:0] gg_r, tcn_r;
  logic signed [15:0] c_r, cn_r, res_r;

  // memories and their read data
  logic signed [15:0] wi_mem  [WDEPTH];
  logic signed [15:0] wr_mem  [WDEPTH];
  logic signed [15:0] gb_mem  [GDEPTH];
  logic signed [15:0] dw_mem  [MAX_HIDDEN];
  logic signed [15:0] hid_mem [HDEPTH];
  logic signed [15:0] cel_mem [HDEPTH];
  logic signed [15:0] gate_mem[ROWS];
  logic signed [15:0] db_r;
  logic signed [15:0] wi_rd, wr_rd, gb_rd, dw_rd, hid_rd, cel_rd, gate_rd;

  logic [WAW-1:0] w_raddr, w_waddr;
  logic [GAW-1:0] gb_raddr, gb_waddr;
  logic [HAW-1:0] hid_raddr, cel_addr, hid_waddr;
  logic           hid_we, cel_we, gate_we;
  logic signed [15:0] hid_wdata, cel_wdata;
  logic           ld_ok, ld_wi, ld_wr, ld_gb, ld_dw, ld_db;

  logic signed [15:0] out_sample_r;
  logic               out_valid_r, put_fire;

  logic j_end, k_end, l_end, clr_done;
  logic [LW-1:0] hl;

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

  assign j_end    = (32'(j_r) + 1 == 32'(hs_r));
  assign k_end    = (32'(k_r) + 1 == 4 * 32'(hs_r));
  assign l_end    = (32'(l_r) + 1 == 32'(nl_r));
  assign clr_done = (clr_r == clr_end_r);
  assign put_fire = (state_r == S_PUT) && (!out_valid_r || out_ready);
  assign rnd      = rnd_sat(acc_r);

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hs_r    <= HSW'(HRST);
      nl_r    <= LSW'(1);
      skip_r  <= 1'b0;
      model_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_HIDDEN: begin
          if (cfg_wdata == 6'd0)                  hs_r <= HSW'(1);
          else if (32'(cfg_wdata) > MAX_HIDDEN)   hs_r <= HSW'(MAX_HIDDEN);
          else                                    hs_r <= HSW'(cfg_wdata);
        end
        CFG_LAYERS: begin
          if (cfg_wdata[1:0] == 2'd0)               nl_r <= LSW'(1);
          else if (32'(cfg_wdata[1:0]) > MAX_LAYERS) nl_r <= LSW'(MAX_LAYERS);
          else                                      nl_r <= LSW'(cfg_wdata[1:0]);
        end
        CFG_SKIP:  skip_r  <= cfg_wdata[0];
        CFG_MODEL: model_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR:  if (clr_done) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_cmd)
            CMD_PROC: state_nxt = model_r ? S_G_BIAS : S_PUT;
            CMD_LOAD: state_nxt = S_LOAD;
            CMD_CLRV: state_nxt = (32'(in_voice) < VOICES) ? S_CLR : S_IDLE;
            CMD_CLRA: state_nxt = S_CLR;
            default:  state_nxt = S_IDLE;
          endcase
        end
      end
      S_LOAD:   state_nxt = S_IDLE;
      S_G_BIAS: state_nxt = S_G_IN;
      S_G_IN:   if (l_r == '0 || j_end) state_nxt = S_G_REC;
      S_G_REC:  if (j_end) state_nxt = S_G_WAIT;
      S_G_WAIT: if (done_r) state_nxt = k_end ? S_EW0 : S_G_BIAS;
      S_EW0:    state_nxt = S_EW1;
      S_EW1:    state_nxt = S_EW2;
      S_EW2:    state_nxt = S_EW3;
      S_EW3:    state_nxt = S_EW4;
      S_EW4:    state_nxt = S_EW5;
      S_EW5:    state_nxt = S_EW6;
      S_EW6:    if (done_r) state_nxt = S_EW7;
      S_EW7:    state_nxt = S_EW8;
      S_EW8: begin
        if (done_r) begin
          if (!j_end)     state_nxt = S_EW0;
          else if (l_end) state_nxt = S_D_BIAS;
          else            state_nxt = S_G_BIAS;
        end
      end
      S_D_BIAS: state_nxt = S_D_W;
      S_D_W:    if (j_end) state_nxt = skip_r ? S_D_SKIP : S_D_WAIT;
      S_D_SKIP: state_nxt = S_D_WAIT;
      S_D_WAIT: if (done_r) state_nxt = S_PUT;
      S_PUT:    if (put_fire) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- outputs
  always_comb begin
    iss_vld     = 1'b0;
    iss_first   = 1'b0;
    iss_last    = 1'b0;
    iss_kind    = K_BIAS;
    l_nxt       = l_r;
    k_nxt       = k_r;
    j_nxt       = j_r;
    gr_nxt      = gr_r;
    clr_nxt     = clr_r;
    clr_end_nxt = clr_end_r;
    hid_we      = 1'b0;
    cel_we      = 1'b0;
    gate_we     = 1'b0;
    hid_waddr   = cel_addr;
    hid_wdata   = rnd;
    cel_wdata   = rnd;
    hl          = l_r;
    unique case (state_r)
      S_CLR: begin
        hid_we    = 1'b1;
        cel_we    = 1'b1;
        hid_waddr = clr_r;
        hid_wdata = '0;
        cel_wdata = '0;
        clr_nxt   = clr_r + HAW'(1);
      end
      S_IDLE: begin
        l_nxt = '0;
        k_nxt = '0;
        j_nxt = '0;
        if (in_valid && in_cmd == CMD_CLRA) begin
          clr_nxt     = '0;
          clr_end_nxt = HAW'(HDEPTH - 1);
        end else begin
          clr_nxt     = HAW'(32'(in_voice) * VS);
          clr_end_nxt = HAW'(32'(in_voice) * VS + VS - 1);
        end
      end
      S_G_BIAS: begin
        iss_vld   = 1'b1;
        iss_first = 1'b1;
        iss_kind  = K_BIAS;
        j_nxt     = '0;
      end
      S_G_IN: begin
        iss_vld = 1'b1;
        hl      = l_r - LW'(1);
        if (l_r == '0) begin
          iss_kind = K_X;
          j_nxt    = '0;
        end else begin
          iss_kind = K_IN;
          j_nxt    = j_end ? '0 : j_r + HIW'(1);
        end
      end
      S_G_REC: begin
        iss_vld  = 1'b1;
        iss_kind = K_REC;
        iss_last = j_end;
        j_nxt    = j_end ? '0 : j_r + HIW'(1);
      end
      S_G_WAIT: begin
        if (done_r) begin
          gate_we = 1'b1;
          k_nxt   = k_r + RW'(1);
          gr_nxt  = '0;
        end
      end
      S_EW0, S_EW1, S_EW2: gr_nxt = gr_r + RW'(hs_r);
      S_EW4: begin
        iss_vld   = 1'b1;
        iss_first = 1'b1;
        iss_kind  = K_FC;
      end
      S_EW5: begin
        iss_vld  = 1'b1;
        iss_last = 1'b1;
        iss_kind = K_IG;
      end
      S_EW6: cel_we = done_r;
      S_EW7: begin
        iss_vld   = 1'b1;
        iss_first = 1'b1;
        iss_last  = 1'b1;
        iss_kind  = K_OT;
      end
      S_EW8: begin
        if (done_r) begin
          hid_we = 1'b1;
          j_nxt  = j_end ? '0 : j_r + HIW'(1);
          gr_nxt = j_end ? '0 : RW'(j_r) + RW'(1);
          if (j_end) begin
            k_nxt = '0;
            if (!l_end) l_nxt = l_r + LW'(1);
          end
        end
      end
      S_D_BIAS: begin
        iss_vld   = 1'b1;
        iss_first = 1'b1;
        iss_kind  = K_DB;
        j_nxt     = '0;
      end
      S_D_W: begin
        iss_vld  = 1'b1;
        iss_kind = K_DW;
        iss_last = j_end && !skip_r;
        j_nxt    = j_end ? '0 : j_r + HIW'(1);
      end
      S_D_SKIP: begin
        iss_vld  = 1'b1;
        iss_last = 1'b1;
        iss_kind = K_SKIP;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- addresses
  assign w_raddr   = WAW'((32'(l_r) * ROWS + 32'(k_r)) * MAX_HIDDEN + 32'(j_r));
  assign gb_raddr  = GAW'(32'(l_r) * ROWS + 32'(k_r));
  assign hid_raddr = (state_r == S_D_W)
                   ? HAW'((32'(v_r) * MAX_LAYERS + 32'(nl_r) - 1) * MAX_HIDDEN + 32'(j_r))
                   : HAW'((32'(v_r) * MAX_LAYERS + 32'(hl)) * MAX_HIDDEN + 32'(j_r));
  assign cel_addr  = HAW'((32'(v_r) * MAX_LAYERS + 32'(l_r)) * MAX_HIDDEN + 32'(j_r));

  // weight loads; out-of-range addresses drop the word
  assign w_waddr  = WAW'((32'(ld_lay_r) * ROWS + 32'(ld_row_r)) * MAX_HIDDEN
                    + 32'(ld_col_r));
  assign gb_waddr = GAW'(32'(ld_lay_r) * ROWS + 32'(ld_row_r));
  assign ld_ok    = (state_r == S_LOAD) && (32'(ld_lay_r) < MAX_LAYERS)
                    && (32'(ld_row_r) < ROWS);
  assign ld_wi    = ld_ok && ld_tab_r == TAB_IN  && (32'(ld_col_r) < MAX_HIDDEN);
  assign ld_wr    = ld_ok && ld_tab_r == TAB_REC && (32'(ld_col_r) < MAX_HIDDEN);
  assign ld_gb    = ld_ok && ld_tab_r == TAB_GB;
  assign ld_dw    = (state_r == S_LOAD) && ld_tab_r == TAB_DW
                    && (32'(ld_col_r) < MAX_HIDDEN);
  assign ld_db    = (state_r == S_LOAD) && ld_tab_r == TAB_DB;

  // ---------------------------------------------------------------- memories
  always_ff @(posedge clk) begin
    if (ld_wi) wi_mem[w_waddr] <= ld_val_r;
    wi_rd <= wi_mem[w_raddr];
  end

  always_ff @(posedge clk) begin
    if (ld_wr) wr_mem[w_waddr] <= ld_val_r;
    wr_rd <= wr_mem[w_raddr];
  end

  always_ff @(posedge clk) begin
    if (ld_gb) gb_mem[gb_waddr] <= ld_val_r;
    gb_rd <= gb_mem[gb_raddr];
  end

  always_ff @(posedge clk) begin
    if (ld_dw) dw_mem[HIW'(ld_col_r)] <= ld_val_r;
    dw_rd <= dw_mem[j_r];
  end

  always_ff @(posedge clk) begin
    if (ld_db) db_r <= ld_val_r;
  end

  always_ff @(posedge clk) begin
    if (hid_we) hid_mem[hid_waddr] <= hid_wdata;
    hid_rd <= hid_mem[hid_raddr];
  end

  always_ff @(posedge clk) begin
    if (cel_we) cel_mem[(state_r == S_CLR) ? clr_r : cel_addr] <= cel_wdata;
    cel_rd <= cel_mem[cel_addr];
  end

  always_ff @(posedge clk) begin
    if (gate_we) gate_mem[k_r] <= rnd;
    gate_rd <= gate_mem[gr_r];
  end

  // ---------------------------------------------------------------- shared MAC
  always_comb begin
    unique case (s1_kind_r)
      K_BIAS: begin mul_a = 17'(gb_rd); mul_b = 17'sd4096; end
      K_X:    begin mul_a = 17'(wi_rd); mul_b = 17'(x_r);  end
      K_IN:   begin mul_a = 17'(wi_rd); mul_b = 17'(hid_rd); end
      K_REC:  begin mul_a = 17'(wr_rd); mul_b = 17'(hid_rd); end
      K_DB:   begin mul_a = 17'(db_r);  mul_b = 17'sd4096; end
      K_DW:   begin mul_a = 17'(dw_rd); mul_b = 17'(hid_rd); end
      K_SKIP: begin mul_a = 17'(x_r);   mul_b = 17'sd4096; end
      K_FC:   begin mul_a = $signed({4'b0000, fg_r}); mul_b = 17'(c_r);   end
      K_IG:   begin mul_a = $signed({4'b0000, ig_r}); mul_b = 17'(gg_r);  end
      K_OT:   begin mul_a = $signed({4'b0000, og_r}); mul_b = 17'(tcn_r); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    p_r <= mul_a * mul_b;
    if (p_vld_r) acc_r <= p_first_r ? ACCW'(p_r) : acc_r + ACCW'(p_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      p_vld_r  <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      s1_vld_r <= iss_vld;
      p_vld_r  <= s1_vld_r;
      if (p_vld_r && p_last_r) done_r <= 1'b1;
      else if (iss_vld)        done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    s1_kind_r  <= iss_kind;
    s1_first_r <= iss_first;
    s1_last_r  <= iss_last;
    p_first_r  <= s1_first_r;
    p_last_r   <= s1_last_r;
  end

  // ---------------------------------------------------------------- element-wise
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_EW1: begin
        ig_r <= sig_q($signed({gate_rd[15], gate_rd}));
        c_r  <= cel_rd;
      end
      S_EW2:   fg_r  <= sig_q($signed({gate_rd[15], gate_rd}));
      S_EW3:   gg_r  <= tanh_q(gate_rd);
      S_EW4:   og_r  <= sig_q($signed({gate_rd[15], gate_rd}));
      S_EW6:   cn_r  <= rnd;
      S_EW7:   tcn_r <= tanh_q(cn_r);
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- control regs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      clr_r     <= '0;
      clr_end_r <= HAW'(HDEPTH - 1);
      l_r       <= '0;
      k_r       <= '0;
      j_r       <= '0;
      gr_r      <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_r     <= clr_nxt;
      clr_end_r <= clr_end_nxt;
      l_r       <= l_nxt;
      k_r       <= k_nxt;
      j_r       <= j_nxt;
      gr_r      <= gr_nxt;
    end
  end

  // latch the accepted word; an out-of-range voice processes as voice 0
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r    <= in_cmd;
      v_r      <= (32'(in_voice) < VOICES) ? VW'(in_voice) : '0;
      x_r      <= in_sample;
      ld_tab_r <= in_weight_table;
      ld_lay_r <= in_weight_layer;
      ld_row_r <= in_weight_row;
      ld_col_r <= in_weight_col;
      ld_val_r <= in_weight_value;
    end
  end

  // result: dense output, or the sample itself when the model is off
  always_ff @(posedge clk) begin
    if (state_r == S_D_WAIT && done_r)                     res_r <= rnd;
    else if (in_valid && in_ready && in_cmd == CMD_PROC)   res_r <= in_sample;
    if (put_fire) out_sample_r <= res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (put_fire) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end

  // cmd_r tags the word in flight; the sequencer does not read it, so it only feeds an unused flag
  logic unused_cmd;
  assign unused_cmd = (cmd_r == CMD_LOAD);

endmodule

[src/lase_chk.sv]
// Port-level checker for the LSTM amp sample engine, bound to the top level.
module lase_chk
  import lase_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic [1:0]         in_cmd,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] out_sample
);

  // a stalled result holds its word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample))
    else $error("result dropped or changed while stalled");

  // a processed sample word leaves in_ready low in the cycle after it is accepted
  a_proc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_cmd == CMD_PROC |=> !in_ready)
    else $error("ready right after a sample word");

  // reset starts the state clearing pass
  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("ready during the clearing pass");

  // no result appears out of reset
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid out of reset");

endmodule

bind lstm_amp_sample_engine_core lase_chk u_lase_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .in_cmd     (in_cmd),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_sample (out_sample)
);

[bench/lase_sample_checker.sv]
// Checker for the LSTM amp sample engine: predicts each output word and compares it.
`timescale 1ns / 100ps

module lase_sample_checker
  import lase_pkg::*;
#(
  parameter int VOICES     = 8,
  parameter int MAX_HIDDEN = 32,
  parameter int MAX_LAYERS = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         in_cmd,
  input  logic [3:0]         in_voice,
  input  logic signed [15:0] in_sample,
  input  logic [2:0]         in_weight_table,
  input  logic [0:0]         in_weight_layer,
  input  logic [6:0]         in_weight_row,
  input  logic [4:0]         in_weight_col,
  input  logic signed [15:0] in_weight_value,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [15:0] out_sample,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_idx,
  input  logic [5:0]         cfg_wdata,
  output int                 fail_count,
  output int                 pending
);

  localparam int ROWS   = 4 * MAX_HIDDEN;
  localparam int STATES = VOICES * MAX_LAYERS * MAX_HIDDEN;

  int hidden_units;
  int layer_count;
  logic skip_on;
  logic model_on;

  logic signed [15:0] hid_mem [STATES];
  logic signed [15:0] cel_mem [STATES];
  logic signed [15:0] win_mem [MAX_LAYERS * ROWS * MAX_HIDDEN];
  logic signed [15:0] wrec_mem [MAX_LAYERS * ROWS * MAX_HIDDEN];
  logic signed [15:0] gbias_mem [MAX_LAYERS * ROWS];
  logic signed [15:0] dw_mem [MAX_HIDDEN];
  logic signed [15:0] dbias;

  logic signed [15:0] expected_samples [$];

  function automatic int round_q12(longint v);
    longint q;
    q = (v + 2048) >>> 12;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return int'(q);
  endfunction

  function automatic int plan_sig(int x);
    int a;
    int y;
    a = (x < 0) ? -x : x;
    if (a >= 20480) y = 4096;
    else if (a >= 9728) y = (a >> 5) + 3456;
    else if (a >= 4096) y = (a >> 3) + 2560;
    else y = (a >> 2) + 2048;
    return (x < 0) ? 4096 - y : y;
  endfunction

  function automatic int plan_tanh(int x);
    return 2 * plan_sig(2 * x) - 4096;
  endfunction

  // Run the layer stack and dense head for one voice; updates hidden and cell state.
  function automatic int amp_forward(int x, int v);
    int gates [ROWS];
    int lin [MAX_HIDDEN];
    longint acc;
    int sbase;
    int wbase;
    int fan_in;
    int ig;
    int fg;
    int gg;
    int og;
    int cn;
    for (int i = 0; i < MAX_HIDDEN; i++) lin[i] = 0;
    lin[0] = x;
    for (int l = 0; l < layer_count; l++) begin
      sbase  = (v * MAX_LAYERS + l) * MAX_HIDDEN;
      fan_in = (l == 0) ? 1 : hidden_units;
      for (int k = 0; k < 4 * hidden_units; k++) begin
        wbase = (l * ROWS + k) * MAX_HIDDEN;
        acc = longint'(gbias_mem[l * ROWS + k]) * 4096;
        for (int j = 0; j < fan_in; j++)
          acc += longint'(win_mem[wbase + j]) * lin[j];
        for (int j = 0; j < hidden_units; j++)
          acc += longint'(wrec_mem[wbase + j]) * longint'(hid_mem[sbase + j]);
        gates[k] = round_q12(acc);
      end
      for (int n = 0; n < hidden_units; n++) begin
        ig = plan_sig(gates[n]);
        fg = plan_sig(gates[hidden_units + n]);
        gg = plan_tanh(gates[2 * hidden_units + n]);
        og = plan_sig(gates[3 * hidden_units + n]);
        cn = round_q12(longint'(fg) * longint'(cel_mem[sbase + n]) + longint'(ig) * gg);
        cel_mem[sbase + n] = 16'(cn);
        hid_mem[sbase + n] = 16'(round_q12(longint'(og) * plan_tanh(cn)));
        lin[n] = int'(hid_mem[sbase + n]);
      end
    end
    acc = longint'(dbias) * 4096;
    for (int n = 0; n < hidden_units; n++)
      acc += longint'(dw_mem[n]) * lin[n];
    if (skip_on) acc += longint'(x) * 4096;
    return round_q12(acc);
  endfunction

  function automatic void wipe_voice(int v);
    for (int i = 0; i < MAX_LAYERS * MAX_HIDDEN; i++) begin
      hid_mem[v * MAX_LAYERS * MAX_HIDDEN + i] = '0;
      cel_mem[v * MAX_LAYERS * MAX_HIDDEN + i] = '0;
    end
  endfunction

  function automatic void store_weight();
    int wi;
    wi = (int'(in_weight_layer) * ROWS + int'(in_weight_row)) * MAX_HIDDEN
         + int'(in_weight_col);
    case (in_weight_table)
      TAB_IN:  win_mem[wi] = in_weight_value;
      TAB_REC: wrec_mem[wi] = in_weight_value;
      TAB_GB:  gbias_mem[int'(in_weight_layer) * ROWS + int'(in_weight_row)] = in_weight_value;
      TAB_DW:  dw_mem[in_weight_col] = in_weight_value;
      TAB_DB:  dbias = in_weight_value;
      default: ;  // drop writes to tables that do not exist
    endcase
  endfunction

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending    = 0;
    foreach (win_mem[i]) win_mem[i] = '0;
    foreach (wrec_mem[i]) wrec_mem[i] = '0;
    foreach (gbias_mem[i]) gbias_mem[i] = '0;
    foreach (dw_mem[i]) dw_mem[i] = '0;
    dbias = '0;
  end

  always @(posedge clk) begin
    int v;
    if (!rst_n) begin
      hidden_units = 20;
      layer_count  = 1;
      skip_on      = 1'b0;
      model_on     = 1'b0;
      for (int i = 0; i < VOICES; i++) wipe_voice(i);
      expected_samples.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_HIDDEN: hidden_units = (cfg_wdata == 0) ? 1 :
                                     (cfg_wdata > MAX_HIDDEN) ? MAX_HIDDEN : int'(cfg_wdata);
          CFG_LAYERS: layer_count = (cfg_wdata[1:0] == 0) ? 1 :
                                    (cfg_wdata[1:0] > MAX_LAYERS) ? MAX_LAYERS :
                                    int'(cfg_wdata[1:0]);
          CFG_SKIP:   skip_on = cfg_wdata[0];
          CFG_MODEL:  model_on = cfg_wdata[0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_samples.size() == 0)
          report_mismatch($sformatf("unexpected word out_sample=%0d", out_sample));
        else if (out_sample !== expected_samples[0])
          report_mismatch($sformatf("out_sample=%0d expected %0d",
                                    out_sample, expected_samples.pop_front()));
        else
          void'(expected_samples.pop_front());
      end
      if (in_valid && in_ready) begin
        case (in_cmd)
          CMD_PROC: begin
            v = (in_voice >= VOICES) ? 0 : int'(in_voice);
            if (!model_on) expected_samples.push_back(in_sample);
            else expected_samples.push_back(16'(amp_forward(int'(in_sample), v)));
          end
          CMD_LOAD: store_weight();
          CMD_CLRV: if (in_voice < VOICES) wipe_voice(int'(in_voice));
          CMD_CLRA: for (int i = 0; i < VOICES; i++) wipe_voice(i);
          default: ;
        endcase
      end
    end
    pending <= expected_samples.size();
  end

endmodule

[bench/lstm_amp_sample_engine_core_tb.sv]
// Testbench top: drives the sample engine and gives the verdict from the checker.
`timescale 1ns / 100ps

module lstm_amp_sample_engine_core_tb;
  import lase_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  // covers the clear-all pass, the longest command that yields no result
  localparam int SETTLE = 600;

  typedef struct {
    logic [1:0]         cmd;
    logic [3:0]         voice;
    logic signed [15:0] sample;
    logic [2:0]         tab;
    logic               lay;
    logic [6:0]         row;
    logic [4:0]         col;
    logic signed [15:0] val;
  } word_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_cmd = CMD_PROC;
  logic [3:0]         in_voice = '0;
  logic signed [15:0] in_sample = '0;
  logic [2:0]         in_weight_table = TAB_IN;
  logic [0:0]         in_weight_layer = '0;
  logic [6:0]         in_weight_row = '0;
  logic [4:0]         in_weight_col = '0;
  logic signed [15:0] in_weight_value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [15:0] out_sample;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_idx = CFG_HIDDEN;
  logic [5:0]         cfg_wdata = '0;

  int fail_count;
  int pending;
  int cycles = 0;
  int burst_left = 0;
  int hold_cnt = 0;
  logic hold_go = 1'b0;
  logic hold_done = 1'b0;
  int n_samples = 0;
  int n_loads = 0;
  int n_clears = 0;
  int n_settings = 0;

  always #1 clk = ~clk;

  lstm_amp_sample_engine_core uut (
    .clk, .rst_n, .in_valid, .in_ready, .in_cmd, .in_voice, .in_sample,
    .in_weight_table, .in_weight_layer, .in_weight_row, .in_weight_col,
    .in_weight_value, .out_valid, .out_ready, .out_sample,
    .cfg_we, .cfg_idx, .cfg_wdata
  );

  lase_sample_checker chk (
    .clk, .rst_n, .in_valid, .in_ready, .in_cmd, .in_voice, .in_sample,
    .in_weight_table, .in_weight_layer, .in_weight_row, .in_weight_col,
    .in_weight_value, .out_valid, .out_ready, .out_sample,
    .cfg_we, .cfg_idx, .cfg_wdata, .fail_count, .pending
  );

  // Hard stop on a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("lstm_amp_sample_engine_core_tb failed");
      $finish;
    end
  end

  // Receiver: rotate through stall patterns chosen by cycles[7:6], and serve one long
  // hold-off on request so the engine backs up and drops in_ready.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_cnt != 0) begin
      out_ready <= 1'b0;
      hold_cnt  <= hold_cnt - 1;
    end else if (hold_go && !hold_done) begin
      out_ready <= 1'b0;
      hold_cnt  <= 400;
      hold_done <= 1'b1;
    end else begin
      case (cycles[7:6])
        2'd0: out_ready <= 1'b1;
        2'd1: out_ready <= $urandom_range(0, 1);
        2'd2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  function automatic word_t make_word(logic [1:0] cmd, logic [3:0] voice,
                                      logic signed [15:0] sample, logic [2:0] tab,
                                      logic lay, logic [6:0] row, logic [4:0] col,
                                      logic signed [15:0] val);
    word_t w;
    w.cmd = cmd; w.voice = voice; w.sample = sample; w.tab = tab;
    w.lay = lay; w.row = row; w.col = col; w.val = val;
    return w;
  endfunction

  function automatic logic signed [15:0] small_weight();
    return 16'($signed($urandom_range(0, 2047)) - 1024);
  endfunction

  // Random word: mostly samples, many weight loads, some clears; every field random.
  function automatic word_t random_word();
    word_t w;
    int pick;
    pick = $urandom_range(0, 99);
    w = make_word(CMD_PROC, 4'($urandom), 16'($urandom), 3'($urandom), 1'($urandom),
                  7'($urandom), 5'($urandom), 16'($urandom));
    if (pick < 62) w.cmd = CMD_PROC;
    else if (pick < 88) w.cmd = CMD_LOAD;
    else if (pick < 96) w.cmd = CMD_CLRV;
    else w.cmd = CMD_CLRA;
    if ($urandom_range(0, 7) == 0) w.sample = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    if ($urandom_range(0, 3) != 0) w.val = small_weight();
    return w;
  endfunction

  // Offer one word in bursts with random gaps; hold until accepted.
  task automatic send_word(word_t w);
    int gap;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                               : $urandom_range(1, 20);
    end
    burst_left--;
    in_valid        <= 1'b1;
    in_cmd          <= w.cmd;
    in_voice        <= w.voice;
    in_sample       <= w.sample;
    in_weight_table <= w.tab;
    in_weight_layer <= w.lay;
    in_weight_row   <= w.row;
    in_weight_col   <= w.col;
    in_weight_value <= w.val;
    do @(posedge clk); while (!in_ready);
    case (w.cmd)
      CMD_PROC: n_samples++;
      CMD_LOAD: n_loads++;
      default:  n_clears++;
    endcase
  endtask

  task automatic send_load(logic [2:0] tab, logic lay, logic [6:0] row, logic [4:0] col,
                           logic signed [15:0] val);
    send_word(make_word(CMD_LOAD, 4'($urandom), 16'($urandom), tab, lay, row, col, val));
  endtask

  task automatic send_cmd(logic [1:0] cmd, logic [3:0] voice, logic signed [15:0] sample);
    send_word(make_word(cmd, voice, sample, 3'($urandom), 1'($urandom), 7'($urandom),
                        5'($urandom), 16'($urandom)));
  endtask

  // Drain all results and let the engine go idle before touching registers.
  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic set_regs(logic [5:0] hid, logic [5:0] lay, logic [5:0] skip,
                          logic [5:0] model);
    cfg_we <= 1'b1; cfg_idx <= CFG_HIDDEN; cfg_wdata <= hid;
    @(posedge clk);
    cfg_idx <= CFG_LAYERS; cfg_wdata <= lay;
    @(posedge clk);
    cfg_idx <= CFG_SKIP; cfg_wdata <= skip;
    @(posedge clk);
    cfg_idx <= CFG_MODEL; cfg_wdata <= model;
    @(posedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // hidden, layers, skip, model, word count; out-of-range register values
  // exercise the clamps
  localparam int NPH = 7;
  int ph_hid   [NPH] = '{2, 63, 1, 5, 3, 8, 1};
  int ph_lay   [NPH] = '{2, 3, 1, 2, 1, 1, 2};
  int ph_skip  [NPH] = '{0, 1, 0, 1, 1, 0, 1};
  int ph_model [NPH] = '{1, 1, 1, 1, 0, 1, 1};
  int ph_words [NPH] = '{60, 4, 60, 50, 40, 30, 46};

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    // hold off until the post-reset clearing pass ends
    @(posedge clk);
    while (!in_ready) @(posedge clk);

    // Reset defaults: model off, so samples pass straight through.
    send_cmd(CMD_PROC, 4'd0, 16'sh7fff);
    send_cmd(CMD_PROC, 4'd5, 16'sh8000);
    send_cmd(CMD_PROC, 4'd15, 16'sh0000);
    send_cmd(CMD_PROC, 4'd2, -16'sd1);
    send_cmd(CMD_CLRV, 4'd12, 16'sh1234);  // voice out of range: dropped
    send_cmd(CMD_CLRA, 4'd3, 16'sh0);      // clear while disabled

    // Fill every weight entry so no read ever hits an unwritten one.
    for (int l = 0; l < 2; l++) begin
      for (int r = 0; r < 128; r++) begin
        send_load(TAB_GB, 1'(l), 7'(r), 5'($urandom), small_weight());
        for (int c = 0; c < 32; c++) begin
          send_load(TAB_IN, 1'(l), 7'(r), 5'(c), small_weight());
          send_load(TAB_REC, 1'(l), 7'(r), 5'(c), small_weight());
        end
      end
    end
    for (int c = 0; c < 32; c++) send_load(TAB_DW, 1'($urandom), 7'($urandom), 5'(c),
                                           small_weight());
    send_load(TAB_DB, 1'b1, 7'd127, 5'd31, small_weight());
    settle();

    // Directed corners with zero registers clamped up, skip and model on.
    set_regs(6'd0, 6'd0, 6'd1, 6'd1);
    send_cmd(CMD_PROC, 4'd3, 16'sh7fff);
    send_cmd(CMD_PROC, 4'd15, 16'sh8000);  // out-of-range voice runs as voice 0
    send_cmd(CMD_PROC, 4'd7, 16'sh0000);
    send_load(TAB_DB, 1'b0, 7'd0, 5'd0, 16'sh7fff);
    send_cmd(CMD_PROC, 4'd1, 16'sh1000);
    send_load(TAB_DB, 1'b0, 7'd0, 5'd0, 16'sh8000);
    send_cmd(CMD_PROC, 4'd2, -16'sd1);
    send_load(3'd5, 1'b1, 7'd127, 5'd31, 16'sh7fff);  // nonexistent tables: dropped
    send_load(3'd7, 1'b0, 7'd3, 5'd3, 16'sh7fff);
    send_load(TAB_DB, 1'b0, 7'd0, 5'd0, 16'sh0100);
    send_cmd(CMD_CLRV, 4'd9, 16'sh0);
    send_cmd(CMD_CLRV, 4'd3, 16'sh0);
    send_cmd(CMD_PROC, 4'd3, 16'sh0800);
    settle();

    for (int p = 0; p < NPH; p++) begin
      set_regs(6'(ph_hid[p]), 6'(ph_lay[p]), 6'(ph_skip[p]), 6'(ph_model[p]));
      // long receiver hold-off while words keep coming
      if (p == 2) hold_go <= 1'b1;
      for (int i = 0; i < ph_words[p]; i++) send_word(random_word());
      settle();
    end

    $display("covered %0d samples, %0d weight loads and %0d clears over %0d register settings,",
             n_samples, n_loads, n_clears, n_settings);
    $display("including clamped registers, saturated outputs and a long output stall");
    if (fail_count == 0) begin
      $display("lstm_amp_sample_engine_core_tb passed");
    end else begin
      $display("lstm_amp_sample_engine_core_tb failed");
    end
    $finish;
  end

endmodule

[filelist.f]
src/lase_pkg.sv
src/lstm_amp_sample_engine_core.sv
src/lase_chk.sv
bench/lase_sample_checker.sv
bench/lstm_amp_sample_engine_core_tb.sv
